// ----- hdl/sparse_table_range_min_max_macros.svh -----
// ----------------------------------------------------------------------------
// Sparse table range min/max - assertion macros
// Shared property wrappers for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SPARSE_TABLE_RANGE_MIN_MAX_MACROS_SVH
`define SPARSE_TABLE_RANGE_MIN_MAX_MACROS_SVH

// same-cycle implication, off during reset
`define STMM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define STMM_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/stmm_pkg.sv -----
// ----------------------------------------------------------------------------
// Sparse table range min/max - package
// Item types, command and status codes, controller/datapath interface structs.
// ----------------------------------------------------------------------------
package stmm_pkg;

    localparam int VALUE_MSB = 31;
    localparam int VALUE_W   = VALUE_MSB + 1;
    localparam int RANGE_W   = 10;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BUILD  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [VALUE_MSB:0] value;
        logic [RANGE_W-1:0]        range_lo;
        logic [RANGE_W-1:0]        range_hi;
    } stmm_in_t;

    typedef struct packed {
        logic signed [VALUE_MSB:0] span_min;
        logic signed [VALUE_MSB:0] span_max;
        logic [STATUS_W-1:0]       status;
    } stmm_out_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;       // capture item fields and result status
        logic clear;
        logic append;
        logic build_start;
        logic level_init;
        logic build_read;
        logic level_next;
        logic set_built;
        logic query_read;
        logic load_out;
    } stmm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic level_end;
        logic last_idx;
    } stmm_stat_t;

endpackage

// ----- hdl/stmm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sparse table range min/max - controller
// Command decode, query and build sequencing, result handshake.
// ----------------------------------------------------------------------------
`include "sparse_table_range_min_max_macros.svh"

module stmm_ctrl
    import stmm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [CMD_W-1:0] s_command,
    output logic             m_valid,
    input  logic             m_ready,
    output stmm_cmd_t        cmd,
    input  stmm_stat_t       stat
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_QADDR  = 3'd1;
    localparam logic [2:0] ST_RESULT = 3'd2;
    localparam logic [2:0] ST_BLEVEL = 3'd3;
    localparam logic [2:0] ST_BRUN   = 3'd4;
    localparam logic [2:0] ST_BDRAIN = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       accept;
    logic       out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.accept = 1'b1;
                    unique case (s_command)
                        CMD_CLEAR: begin
                            cmd.clear = 1'b1;
                        end
                        CMD_APPEND: begin
                            if (stat.full) begin
                                state_next = ST_RESULT;
                            end else begin
                                cmd.append = 1'b1;
                            end
                        end
                        CMD_BUILD: begin
                            cmd.build_start = 1'b1;
                            state_next      = ST_BLEVEL;
                        end
                        CMD_QUERY: begin
                            state_next = ST_QADDR;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_QADDR: begin
                cmd.query_read = 1'b1;
                state_next     = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_BLEVEL: begin
                if (stat.level_end) begin
                    cmd.set_built = 1'b1;
                    state_next    = ST_IDLE;
                end else begin
                    cmd.level_init = 1'b1;
                    state_next     = ST_BRUN;
                end
            end
            ST_BRUN: begin
                cmd.build_read = 1'b1;
                if (stat.last_idx) begin
                    state_next = ST_BDRAIN;
                end
            end
            ST_BDRAIN: begin
                // last write of the level lands this cycle
                cmd.level_next = 1'b1;
                state_next     = ST_BLEVEL;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `STMM_ASSERT_IMP(a_load_into_free_slot, aclk, aresetn, cmd.load_out, !m_valid_reg || m_ready, "result loaded over an item not yet taken")
    `STMM_ASSERT_NXT(a_load_shows_result, aclk, aresetn, cmd.load_out, m_valid_reg, "loaded result not presented")
    `STMM_ASSERT_IMP(a_no_append_when_full, aclk, aresetn, cmd.append, !stat.full, "append issued with array full")
    `STMM_ASSERT_NXT(a_drain_then_level, aclk, aresetn, state_reg == ST_BDRAIN, state_reg == ST_BLEVEL, "build drain did not return to level check")

endmodule

// ----- hdl/stmm_dp.sv -----
// ----------------------------------------------------------------------------
// Sparse table range min/max - datapath
// Min/max level tables, element count, query address math, build pipeline.
// ----------------------------------------------------------------------------
module stmm_dp
    import stmm_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int LEVELS     = 11,
    parameter int DATA_WIDTH = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  stmm_in_t   s_item,
    input  stmm_cmd_t  cmd,
    output stmm_stat_t stat,
    output stmm_out_t  m_item
);

    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int LW    = $clog2(LEVELS);
    localparam int PCW   = $clog2(LEVELS + 1);
    localparam int LEN_W = RANGE_W + 1;
    localparam int QPW   = $clog2(LEN_W);
    localparam int CMPW  = (CW > RANGE_W) ? CW : RANGE_W;
    localparam int XW    = (IW > LEN_W) ? IW : LEN_W;
    localparam int SW    = (CW > LEVELS) ? CW : LEVELS;
    localparam logic [DATA_WIDTH-1:0] SIGN_BIT = DATA_WIDTH'(1) << (DATA_WIDTH - 1);

    function automatic logic [QPW-1:0] floor_log2(input logic [LEN_W-1:0] x);
        logic [QPW-1:0] r;
        r = '0;
        for (int k = 0; k < LEN_W; k++) begin
            if (x[k]) begin
                r = QPW'(k);
            end
        end
        return r;
    endfunction

    // values stored offset binary so unsigned compares order them
    logic [DATA_WIDTH-1:0] min_mem [LEVELS][DEPTH];
    logic [DATA_WIDTH-1:0] max_mem [LEVELS][DEPTH];

    logic [CW-1:0]         count_reg;
    logic                  built_reg;
    logic [RANGE_W-1:0]    lo_reg, hi_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic [PCW-1:0]        p_reg;
    logic [IW-1:0]         idx_reg, lim_reg, wr_idx_reg;
    logic                  wr_pend_reg;
    logic [DATA_WIDTH-1:0] min_a_reg, min_b_reg, max_a_reg, max_b_reg;
    stmm_out_t             m_item_reg;

    logic                  query_bad;
    logic [LEN_W-1:0]      len_next;
    logic [SW-1:0]         lvl_len;
    logic [QPW-1:0]        q_pfull;
    logic [LW-1:0]         q_lvl;
    logic [XW-1:0]         q_second;
    logic [PCW-1:0]        b_prev;
    logic [LW-1:0]         rd_lvl, wr_lvl;
    logic [IW-1:0]         rd_idx_a, rd_idx_b, wr_idx, b_idx_b;
    logic                  rd_en, wr_en;
    logic [DATA_WIDTH-1:0] app_val, pair_min, pair_max, wr_min, wr_max;
    logic [DATA_WIDTH-1:0] out_min, out_max;

    // item checks at acceptance
    assign query_bad = !built_reg || (count_reg == '0)
                       || (s_item.range_lo > s_item.range_hi)
                       || (CMPW'(s_item.range_hi) >= CMPW'(count_reg));
    assign len_next  = LEN_W'(s_item.range_hi) - LEN_W'(s_item.range_lo) + LEN_W'(1);

    // build level bookkeeping
    assign lvl_len        = SW'(1) << p_reg;
    assign stat.full      = (count_reg == CW'(DEPTH));
    assign stat.level_end = (p_reg >= PCW'(LEVELS)) || (lvl_len > SW'(count_reg));
    assign stat.last_idx  = (idx_reg == lim_reg);
    assign b_prev         = p_reg - PCW'(1);
    assign b_idx_b        = IW'(SW'(idx_reg) + (SW'(1) << b_prev));

    // query: two blocks of 2^p at lo and at hi - 2^p + 1
    assign q_pfull  = floor_log2(len_reg);
    assign q_lvl    = (32'(q_pfull) > LEVELS - 1) ? LW'(LEVELS - 1) : LW'(q_pfull);
    assign q_second = XW'(hi_reg) + XW'(1) - (XW'(1) << q_lvl);

    assign rd_en    = cmd.query_read || cmd.build_read;
    assign rd_lvl   = cmd.query_read ? q_lvl : b_prev[LW-1:0];
    assign rd_idx_a = cmd.query_read ? IW'(lo_reg) : idx_reg;
    assign rd_idx_b = cmd.query_read ? q_second[IW-1:0] : b_idx_b;

    assign pair_min = (min_a_reg < min_b_reg) ? min_a_reg : min_b_reg;
    assign pair_max = (max_a_reg > max_b_reg) ? max_a_reg : max_b_reg;

    assign app_val = DATA_WIDTH'(s_item.value) ^ SIGN_BIT;
    assign wr_en   = cmd.append || wr_pend_reg;
    assign wr_lvl  = wr_pend_reg ? p_reg[LW-1:0] : '0;
    assign wr_idx  = wr_pend_reg ? wr_idx_reg : count_reg[IW-1:0];
    assign wr_min  = wr_pend_reg ? pair_min : app_val;
    assign wr_max  = wr_pend_reg ? pair_max : app_val;

    assign out_min = pair_min ^ SIGN_BIT;
    assign out_max = pair_max ^ SIGN_BIT;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            min_mem[wr_lvl][wr_idx] <= wr_min;
            max_mem[wr_lvl][wr_idx] <= wr_max;
        end
        if (rd_en) begin
            min_a_reg <= min_mem[rd_lvl][rd_idx_a];
            min_b_reg <= min_mem[rd_lvl][rd_idx_b];
            max_a_reg <= max_mem[rd_lvl][rd_idx_a];
            max_b_reg <= max_mem[rd_lvl][rd_idx_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            built_reg   <= 1'b0;
            wr_pend_reg <= 1'b0;
        end else begin
            if (cmd.clear) begin
                count_reg <= '0;
                built_reg <= 1'b0;
            end else if (cmd.append) begin
                count_reg <= count_reg + CW'(1);
                built_reg <= 1'b0;
            end else if (cmd.set_built) begin
                built_reg <= 1'b1;
            end
            wr_pend_reg <= cmd.build_read;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            lo_reg         <= s_item.range_lo;
            hi_reg         <= s_item.range_hi;
            len_reg        <= len_next;
            res_status_reg <= (s_item.command != CMD_QUERY) ? STATUS_OVERFLOW :
                              (query_bad ? STATUS_BAD_RANGE : STATUS_OK);
        end
        if (cmd.build_start) begin
            p_reg <= PCW'(1);
        end else if (cmd.level_next) begin
            p_reg <= p_reg + PCW'(1);
        end
        if (cmd.level_init) begin
            idx_reg <= '0;
            lim_reg <= IW'(SW'(count_reg) - lvl_len);
        end else if (cmd.build_read) begin
            idx_reg <= idx_reg + IW'(1);
        end
        if (cmd.build_read) begin
            wr_idx_reg <= idx_reg;
        end
        if (cmd.load_out) begin
            m_item_reg.status <= res_status_reg;
            if (res_status_reg == STATUS_OK) begin
                m_item_reg.span_min <= VALUE_W'(out_min);
                m_item_reg.span_max <= VALUE_W'(out_max);
            end else begin
                m_item_reg.span_min <= '0;
                m_item_reg.span_max <= '0;
            end
        end
    end

    assign m_item = m_item_reg;

endmodule

// ----- hdl/sparse_table_range_min_max.sv -----
// ----------------------------------------------------------------------------
// Sparse table range min/max query - top level
// Clear and append finish at acceptance; an append to a full array goes to the
//   result state and registers its overflow item once the output slot is free.
// Query (one at a time): table read in the address state, then compare and
//   register in the result state, which waits for a free output slot.
// Build: level check, pair reads and a drain per level p with 2^p <= count.
// Reset clears count, built flag and control; table contents stay undefined.
// ----------------------------------------------------------------------------
module sparse_table_range_min_max
    import stmm_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int LEVELS     = 11,
    parameter int DATA_WIDTH = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  stmm_in_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output stmm_out_t m_item
);

    stmm_cmd_t  cmd;
    stmm_stat_t stat;

    stmm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_item.command),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    stmm_dp #(
        .DEPTH      (DEPTH),
        .LEVELS     (LEVELS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .stat    (stat),
        .m_item  (m_item)
    );

endmodule
